// ===== rtl/i2crm_pkg.sv =====
package i2crm_pkg;

    // Command kinds carried on the input tuser
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_QUEUE = 2'd3;

    // Sequencer phase codes
    localparam int PHASE_W = 5;
    localparam logic [PHASE_W-1:0] PH_IDLE        = 5'd0;
    localparam logic [PHASE_W-1:0] PH_W_START     = 5'd1;
    localparam logic [PHASE_W-1:0] PH_W_ADDR      = 5'd2;
    localparam logic [PHASE_W-1:0] PH_W_ADDR_ACK  = 5'd3;
    localparam logic [PHASE_W-1:0] PH_W_INDEX     = 5'd4;
    localparam logic [PHASE_W-1:0] PH_W_INDEX_ACK = 5'd5;
    localparam logic [PHASE_W-1:0] PH_W_DATA      = 5'd6;
    localparam logic [PHASE_W-1:0] PH_W_DATA_ACK  = 5'd7;
    localparam logic [PHASE_W-1:0] PH_R_START     = 5'd8;
    localparam logic [PHASE_W-1:0] PH_R_ADDR      = 5'd9;
    localparam logic [PHASE_W-1:0] PH_R_ADDR_ACK  = 5'd10;
    localparam logic [PHASE_W-1:0] PH_R_INDEX     = 5'd11;
    localparam logic [PHASE_W-1:0] PH_R_INDEX_ACK = 5'd12;
    localparam logic [PHASE_W-1:0] PH_R_RSTART    = 5'd13;
    localparam logic [PHASE_W-1:0] PH_R_RADDR     = 5'd14;
    localparam logic [PHASE_W-1:0] PH_R_RADDR_ACK = 5'd15;
    localparam logic [PHASE_W-1:0] PH_R_RECV      = 5'd16;
    localparam logic [PHASE_W-1:0] PH_R_MACK      = 5'd17;
    localparam logic [PHASE_W-1:0] PH_STOP        = 5'd18;
    localparam logic [PHASE_W-1:0] PH_STOP_FAIL   = 5'd19;

    // Acknowledge poll outcome
    localparam logic [1:0] ACK_PENDING = 2'd0;
    localparam logic [1:0] ACK_OK      = 2'd1;
    localparam logic [1:0] ACK_TIMEOUT = 2'd2;

    localparam logic [7:0] POLL_LIMIT_RESET = 8'd250;
    localparam int         QUEUE_DEPTH_DEF  = 16;

    // Stream widths
    localparam int IN_DATA_W  = 48;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    // Result field positions in the output tdata
    localparam int O_SCL      = 0;
    localparam int O_SDA      = 1;
    localparam int O_DRIVE    = 2;
    localparam int O_RBYTE_LO = 3;
    localparam int O_RVALID   = 11;
    localparam int O_DONE     = 12;
    localparam int O_AFAIL    = 13;
    localparam int O_LNACK    = 14;
    localparam int O_BUSY     = 15;
    localparam int O_REFUSED  = 16;

endpackage

// ===== rtl/i2c_register_master_unit.sv =====
// Channel   | Dir | Beat contents
// ----------+-----+------------------------------------------------------------
// s_axis    | in  | one bus tick: command kind (tuser), device addr, reg index,
//           |     | byte count, byte to queue, sampled SDA (tdata)
// m_axis    | out | one result per tick: SCL/SDA drive, read byte, status flags
// cfg       | in  | ack_poll_limit write (8 bit)
//
// Each input beat is one bus timing tick. The sequencer steps once per beat in
// a single registered pass, so one beat is taken every cycle while not stalled;
// its result shows on m_axis in the following cycle. A full result register that
// is not taken stalls s_axis (s_axis_tready = output empty or being drained).
// Reset (rst_n low, async) returns to idle with an empty queue and limit 250.
// Queued write bytes sit in a RAM with a registered read, prefetched at the
// queue head; the head only moves many ticks after any queue write.
module i2c_register_master_unit #(
    parameter int QUEUE_DEPTH = i2crm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // tuser: mode[1:0]
    // tdata: slave_addr[7:0], reg_index[15:8], byte_count[31:16],
    //        write_byte[39:32], sda_sample[40], zero pad[47:41]
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [i2crm_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [i2crm_pkg::IN_USER_W-1:0]  s_axis_tuser,
    // tdata: scl_level[0], sda_level[1], sda_drive[2], read_byte[10:3],
    //        read_valid[11], done_res[12], addr_failed[13], late_nack[14],
    //        busy_res[15], cmd_refused[16], zero pad[23:17]
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [i2crm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // ack_poll_limit
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [7:0]                       cfg_data
);

    import i2crm_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

    // ---------------------------------------------------------------- input unpack
    logic [1:0]  mode;
    logic [7:0]  slave_addr;
    logic [7:0]  reg_index;
    logic [15:0] byte_count;
    logic [7:0]  write_byte;
    logic        sda_sample;

    assign mode       = s_axis_tuser[1:0];
    assign slave_addr = s_axis_tdata[7:0];
    assign reg_index  = s_axis_tdata[15:8];
    assign byte_count = s_axis_tdata[31:16];
    assign write_byte = s_axis_tdata[39:32];
    assign sda_sample = s_axis_tdata[40];

    // ---------------------------------------------------------------- state
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [1:0]         ticks_reg, ticks_next;
    logic [3:0]         bit_reg, bit_next;
    logic [7:0]         shifter_reg, shifter_next;
    logic [15:0]        bytes_reg, bytes_next;
    logic [7:0]         poll_reg, poll_next;
    logic [7:0]         addr_reg, addr_next;
    logic [7:0]         index_reg, index_next;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               nack_reg, nack_next;
    logic [7:0]         limit_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic in_accept;
    logic ram_we;
    logic [7:0] ram_rdata;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    i2crm_ram #(
        .WIDTH (8),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (write_byte),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- one tick
    logic       busy;
    logic       o_scl, o_sda, o_drv;
    logic [7:0] rbyte;
    logic       rvalid, done, afail, refused;
    logic [1:0] ack_st;
    logic [1:0] ack_ticks;
    logic [7:0] ack_poll;
    logic       ack_scl;
    logic [3:0] bit_inc;
    logic [7:0] recv_sh;
    logic [15:0] bytes_dec;

    assign busy    = (phase_reg != PH_IDLE);
    assign bit_inc = bit_reg + 4'd1;
    assign recv_sh = {shifter_reg[6:0], sda_sample};

    // Acknowledge poll: SCL low, SCL high, then sample SDA with SCL held high
    always_comb
    begin
        ack_st    = ACK_PENDING;
        ack_ticks = ticks_reg;
        ack_poll  = poll_reg;
        ack_scl   = 1'b1;
        priority if (ticks_reg == 2'd0)
        begin
            ack_scl   = 1'b0;
            ack_ticks = 2'd1;
        end
        else if (ticks_reg == 2'd1)
        begin
            ack_ticks = 2'd2;
        end
        else if (!sda_sample)
        begin
            ack_st = ACK_OK;
        end
        else if (poll_reg >= limit_reg)
        begin
            ack_st = ACK_TIMEOUT;
        end
        else
        begin
            ack_poll = poll_reg + 8'd1;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        ticks_next   = ticks_reg;
        bit_next     = bit_reg;
        shifter_next = shifter_reg;
        bytes_next   = bytes_reg;
        poll_next    = poll_reg;
        addr_next    = addr_reg;
        index_next   = index_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        fill_next    = fill_reg;
        nack_next    = nack_reg;
        ram_we       = 1'b0;
        o_scl        = 1'b1;
        o_sda        = 1'b1;
        o_drv        = 1'b0;
        rbyte        = 8'd0;
        rvalid       = 1'b0;
        done         = 1'b0;
        afail        = 1'b0;
        refused      = 1'b0;
        bytes_dec    = bytes_reg - 16'd1;

        // command decode
        if (mode != MODE_TICK && busy)
        begin
            refused = 1'b1;
        end
        else if (mode == MODE_QUEUE)
        begin
            if (fill_reg >= FULL_FILL)
            begin
                refused = 1'b1;
            end
            else
            begin
                // RAM write only on an accepted queue beat
                ram_we    = in_accept;
                tail_next = (tail_reg == LAST_SLOT) ? '0 : tail_reg + PTR_W'(1);
                fill_next = fill_reg + FILL_W'(1);
            end
        end
        else if (mode == MODE_WRITE || mode == MODE_READ)
        begin
            if (mode == MODE_WRITE && byte_count > 16'(fill_reg))
            begin
                refused = 1'b1;
            end
            else
            begin
                addr_next    = slave_addr;
                index_next   = reg_index;
                bytes_next   = byte_count;
                nack_next    = 1'b0;
                shifter_next = 8'd0;
                phase_next   = (mode == MODE_WRITE) ? PH_W_START : PH_R_START;
                ticks_next   = 2'd0;
                bit_next     = 4'd0;
                poll_next    = 8'd0;
            end
        end

        // bus sequencer
        if (busy)
        begin
            unique case (phase_reg)
                PH_W_START, PH_R_START, PH_R_RSTART:
                begin
                    o_drv = 1'b1;
                    o_scl = (ticks_reg != 2'd0);
                    o_sda = (ticks_reg != 2'd2);
                    if (ticks_reg < 2'd2)
                    begin
                        ticks_next = ticks_reg + 2'd1;
                    end
                    else
                    begin
                        ticks_next = 2'd0;
                        bit_next   = 4'd0;
                        poll_next  = 8'd0;
                        if (phase_reg == PH_R_RSTART)
                        begin
                            phase_next   = PH_R_RADDR;
                            shifter_next = addr_reg | 8'h01;
                        end
                        else
                        begin
                            phase_next   = (phase_reg == PH_W_START) ? PH_W_ADDR : PH_R_ADDR;
                            shifter_next = addr_reg;
                        end
                    end
                end
                PH_W_ADDR, PH_W_INDEX, PH_W_DATA, PH_R_ADDR, PH_R_INDEX, PH_R_RADDR:
                begin
                    o_drv = 1'b1;
                    o_sda = shifter_reg[7];
                    o_scl = (ticks_reg == 2'd1);
                    if (ticks_reg < 2'd2)
                    begin
                        ticks_next = ticks_reg + 2'd1;
                    end
                    else
                    begin
                        ticks_next   = 2'd0;
                        shifter_next = {shifter_reg[6:0], 1'b0};
                        if (bit_inc >= 4'd8)
                        begin
                            bit_next   = 4'd0;
                            poll_next  = 8'd0;
                            phase_next = phase_reg + PHASE_W'(1);
                        end
                        else
                        begin
                            bit_next = bit_inc;
                        end
                    end
                end
                PH_W_ADDR_ACK, PH_R_ADDR_ACK, PH_W_INDEX_ACK, PH_W_DATA_ACK,
                PH_R_INDEX_ACK, PH_R_RADDR_ACK:
                begin
                    o_scl      = ack_scl;
                    ticks_next = ack_ticks;
                    poll_next  = ack_poll;
                    if (ack_st == ACK_TIMEOUT && phase_reg != PH_W_ADDR_ACK
                        && phase_reg != PH_R_ADDR_ACK)
                    begin
                        nack_next = 1'b1;
                    end
                    if (ack_st != ACK_PENDING)
                    begin
                        ticks_next = 2'd0;
                        bit_next   = 4'd0;
                        poll_next  = 8'd0;
                        unique case (phase_reg)
                            PH_W_ADDR_ACK, PH_R_ADDR_ACK:
                            begin
                                if (ack_st == ACK_OK)
                                begin
                                    phase_next   = (phase_reg == PH_W_ADDR_ACK) ?
                                                   PH_W_INDEX : PH_R_INDEX;
                                    shifter_next = index_reg;
                                end
                                else
                                begin
                                    phase_next = PH_STOP_FAIL;
                                end
                            end
                            PH_W_INDEX_ACK, PH_W_DATA_ACK:
                            begin
                                // next queued byte, or stop
                                if (bytes_reg != 16'd0 && fill_reg != '0)
                                begin
                                    shifter_next = ram_rdata;
                                    head_next    = (head_reg == LAST_SLOT) ?
                                                   '0 : head_reg + PTR_W'(1);
                                    fill_next    = fill_reg - FILL_W'(1);
                                    bytes_next   = bytes_dec;
                                    phase_next   = PH_W_DATA;
                                end
                                else
                                begin
                                    bytes_next = 16'd0;
                                    phase_next = PH_STOP;
                                end
                            end
                            PH_R_INDEX_ACK:
                            begin
                                phase_next = PH_R_RSTART;
                            end
                            default:
                            begin
                                shifter_next = 8'd0;
                                phase_next   = (bytes_reg != 16'd0) ? PH_R_RECV : PH_STOP;
                            end
                        endcase
                    end
                end
                PH_R_RECV:
                begin
                    if (ticks_reg == 2'd0)
                    begin
                        o_scl      = 1'b0;
                        ticks_next = 2'd1;
                    end
                    else
                    begin
                        shifter_next = recv_sh;
                        ticks_next   = 2'd0;
                        if (bit_inc >= 4'd8)
                        begin
                            rbyte      = recv_sh;
                            rvalid     = 1'b1;
                            bit_next   = 4'd0;
                            poll_next  = 8'd0;
                            phase_next = PH_R_MACK;
                        end
                        else
                        begin
                            bit_next = bit_inc;
                        end
                    end
                end
                PH_R_MACK:
                begin
                    // ACK every byte but the last, which gets NACK
                    o_drv = 1'b1;
                    o_sda = (bytes_reg == 16'd1);
                    o_scl = (ticks_reg == 2'd1);
                    if (ticks_reg < 2'd2)
                    begin
                        ticks_next = ticks_reg + 2'd1;
                    end
                    else
                    begin
                        if (bytes_reg != 16'd0)
                        begin
                            bytes_next = bytes_dec;
                        end
                        shifter_next = 8'd0;
                        ticks_next   = 2'd0;
                        bit_next     = 4'd0;
                        poll_next    = 8'd0;
                        phase_next   = (bytes_reg > 16'd1) ? PH_R_RECV : PH_STOP;
                    end
                end
                PH_STOP, PH_STOP_FAIL:
                begin
                    o_drv = 1'b1;
                    o_scl = (ticks_reg != 2'd0);
                    o_sda = (ticks_reg == 2'd2);
                    if (ticks_reg < 2'd2)
                    begin
                        ticks_next = ticks_reg + 2'd1;
                    end
                    else
                    begin
                        done       = 1'b1;
                        afail      = (phase_reg == PH_STOP_FAIL);
                        bytes_next = 16'd0;
                        ticks_next = 2'd0;
                        bit_next   = 4'd0;
                        poll_next  = 8'd0;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    ticks_next = 2'd0;
                    bit_next   = 4'd0;
                    poll_next  = 8'd0;
                    phase_next = PH_IDLE;
                end
            endcase
        end

        out_data_next = {7'd0, refused, busy, nack_next, afail, done, rvalid, rbyte,
                         o_drv, o_sda, o_scl};
    end

    // ---------------------------------------------------------------- output stage
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            ticks_reg     <= 2'd0;
            bit_reg       <= 4'd0;
            shifter_reg   <= 8'd0;
            bytes_reg     <= 16'd0;
            poll_reg      <= 8'd0;
            addr_reg      <= 8'd0;
            index_reg     <= 8'd0;
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            nack_reg      <= 1'b0;
            limit_reg     <= POLL_LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (in_accept)
            begin
                phase_reg   <= phase_next;
                ticks_reg   <= ticks_next;
                bit_reg     <= bit_next;
                shifter_reg <= shifter_next;
                bytes_reg   <= bytes_next;
                poll_reg    <= poll_next;
                addr_reg    <= addr_next;
                index_reg   <= index_next;
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                fill_reg    <= fill_next;
                nack_reg    <= nack_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== rtl/i2crm_ram.sv =====
module i2crm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/i2crm_checker.sv =====
module i2crm_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [i2crm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    import i2crm_pkg::*;

    logic out_beat;
    logic prev_done_reg;

    assign out_beat = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_done_reg <= 1'b0;
        end
        else if (out_beat)
        begin
            prev_done_reg <= m_axis_tdata[O_DONE];
        end
    end

    // every accepted tick yields a result on the next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted tick produced no result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // after a stop completes, the next tick starts idle
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && prev_done_reg |-> !m_axis_tdata[O_BUSY])
        else $error("busy right after transaction done");

    // a received byte completes with SCL high and SDA released
    a_read_sample: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat && m_axis_tdata[O_RVALID] |->
            m_axis_tdata[O_BUSY] && m_axis_tdata[O_SCL] && !m_axis_tdata[O_DRIVE])
        else $error("read byte outside a receive sample");

endmodule

bind i2c_register_master_unit i2crm_checker u_i2crm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
